FILE: rtl/nco_pkg.sv
package nco_pkg;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_PHASE_OFFSET = 2'd1,
    REG_WAVE_SELECT  = 2'd2,
    REG_AMPLITUDE    = 2'd3
  } reg_idx_e;

  // Waveform codes; anything above WAVE_SILENCE is silent as well
  localparam logic [2:0] WAVE_SAW      = 3'd0;
  localparam logic [2:0] WAVE_SINE     = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_SILENCE  = 3'd4;

  // Unity gain in Q1.15
  localparam logic [15:0] AMP_UNITY = 16'd32768;

  // Q30 constants for building the sine table
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

FILE: rtl/nco_sine_rom.sv
module nco_sine_rom #(
  parameter int SINE_TABLE_SIZE = 1024,
  parameter int AW = $clog2(SINE_TABLE_SIZE)
) (
  input  logic                 clk_i,
  input  logic [AW-1:0]        addr_i,
  output logic signed [15:0]   data_o
);
  import nco_pkg::*;

  // round(32767 * sin(2*pi*k/N)) by a fixed-point Taylor series, quarter-wave folded
  function automatic logic signed [15:0] sine_entry(input logic [31:0] k);
    logic [63:0] fr, r, x, x2, t, s, v;
    logic [1:0]  quad;
    fr   = {k, 32'd0} / 64'(SINE_TABLE_SIZE);
    quad = fr[31:30];
    r    = {34'd0, fr[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

  logic signed [15:0] rom [SINE_TABLE_SIZE];

  for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_tab
    localparam logic signed [15:0] Entry = sine_entry(32'(g));
    assign rom[g] = Entry;
  end

  always_ff @(posedge clk_i) begin
    data_o <= rom[addr_i];
  end

endmodule

FILE: rtl/phase_accumulator_waveform_osc_unit.sv
// Oscillator, one output sample per input transfer.
// Steps: phase, waveform value, amplitude multiply, output; sine inserts a table
// position, two table reads and an interpolation multiply before the waveform.
// No new input until the result is loaded (held while output is full); one shared
// 18x18 multiplier and a single-port sine ROM are reused. Input ready only in idle.
// Reset: base phase 0, step/offset 0, wave saw, amplitude unity; no clearing pass.
module phase_accumulator_waveform_osc_unit #(
  parameter int SINE_TABLE_SIZE = 1024,
  parameter int PHASE_BITS      = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  nco_pkg::reg_idx_e     cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  // input tick
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    sample_o,
  output logic                  sync_pulse_o
);
  import nco_pkg::*;

  localparam int AW    = $clog2(SINE_TABLE_SIZE);
  localparam int PB    = PHASE_BITS;
  localparam int UP_SH = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int DN_SH = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int PW    = 32 + AW;

  localparam logic [PB-1:0] PH_HALF = {1'b1, {(PB-1){1'b0}}};
  localparam logic [AW-1:0] K_LAST  = AW'(SINE_TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,   // shifted phase and sync flag
    S_POS,     // table position = phase * table size
    S_RDA,     // ROM read of entry k
    S_RDB,     // ROM read of entry k+1, capture entry k
    S_MUL1,    // (b - a) * frac on the shared multiplier
    S_WAVE,    // waveform value
    S_MUL2,    // wave * amplitude on the shared multiplier
    S_OUT      // round, saturate, hand off to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers; host must write only while idle, block does not check.
  // ---------------------------------------------------------------------------
  logic [31:0] phase_step_q, phase_offset_q;
  logic [2:0]  wave_select_q;
  logic [15:0] amplitude_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      phase_offset_q <= '0;
      wave_select_q  <= WAVE_SAW;
      amplitude_q    <= AMP_UNITY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        REG_PHASE_OFFSET: phase_offset_q <= cfg_data_i;
        REG_WAVE_SELECT:  wave_select_q  <= cfg_data_i[2:0];
        REG_AMPLITUDE:    amplitude_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Registers are scaled by 2^32; move them onto the phase grid.
  logic [PB-1:0] step_al, offset_al;
  assign step_al   = (PHASE_BITS >= 32) ? (PB'(phase_step_q) << UP_SH)
                                        : PB'(phase_step_q >> DN_SH);
  assign offset_al = (PHASE_BITS >= 32) ? (PB'(phase_offset_q) << UP_SH)
                                        : PB'(phase_offset_q >> DN_SH);

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  state_e             state_q;
  logic [PB-1:0]      base_phase_q;
  logic [PB-1:0]      ph_q;
  logic               sync_q;
  logic [AW-1:0]      k_q;
  logic [15:0]        f_q;
  logic signed [15:0] a_q;
  logic signed [16:0] w_q;
  logic signed [35:0] prod_q;
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               sync_out_q;

  // ---------------------------------------------------------------------------
  // Sine ROM: one registered read per cycle, address muxed by the sequencer.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]      k1;
  logic [AW-1:0]      rom_addr;
  logic signed [15:0] rom_data;

  assign k1       = (k_q == K_LAST) ? '0 : k_q + AW'(1);
  assign rom_addr = (state_q == S_RDB) ? k1 : k_q;

  nco_sine_rom #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
    .AW              (AW)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // ---------------------------------------------------------------------------
  // Phase-derived values
  // ---------------------------------------------------------------------------
  logic [31:0]   p32;
  logic [15:0]   p16;
  logic [PW-1:0] pos;
  logic [PB-1:0] ph_sum;

  assign ph_sum = base_phase_q + offset_al;
  assign p32    = (PHASE_BITS >= 32) ? 32'(ph_q >> UP_SH) : (32'(ph_q) << DN_SH);
  assign p16    = ph_q[PB-1 -: 16];
  // table position: integer part selects the entry, bits 31..16 the fraction
  assign pos    = PW'(p32) * PW'(SINE_TABLE_SIZE);

  // ---------------------------------------------------------------------------
  // Waveform value
  // ---------------------------------------------------------------------------
  logic signed [17:0] p16x2, tri_w, sine_w;
  logic signed [16:0] wave_d;

  assign p16x2  = $signed({1'b0, p16, 1'b0});
  assign tri_w  = (ph_q <= PH_HALF) ? (p16x2 - 18'sd32768) : (18'sd98304 - p16x2);
  // a + floor((b - a) * f / 2^16); the product sits in prod_q
  assign sine_w = 18'(a_q) + 18'(prod_q >>> 16);

  always_comb begin
    case (wave_select_q)
      WAVE_SAW:      wave_d = 17'($signed(p16));
      WAVE_SINE:     wave_d = sine_w[16:0];
      WAVE_TRIANGLE: wave_d = tri_w[16:0];
      WAVE_SQUARE:   wave_d = (ph_q <= PH_HALF) ? 17'sd32768 : -17'sd32768;
      default:       wave_d = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: interpolation step, then amplitude scaling
  // ---------------------------------------------------------------------------
  logic signed [16:0] diff;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;

  assign diff = 17'(rom_data) - 17'(a_q);

  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = 18'(diff);
      mul_b = $signed({2'b00, f_q});
    end else begin
      mul_a = 18'(w_q);
      mul_b = $signed({2'b00, amplitude_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Round to nearest (floor of +1/2) and saturate to 16 bits
  // ---------------------------------------------------------------------------
  logic signed [35:0] rnd;
  logic signed [20:0] y;
  logic signed [15:0] sat;

  assign rnd = (prod_q + 36'sd16384) >>> 15;
  assign y   = rnd[20:0];

  always_comb begin
    if (y > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (y < -21'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = y[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic in_xfer, out_xfer, out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  // output register free now or emptied at this edge
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_phase_q <= '0;
      ph_q         <= '0;
      sync_q       <= 1'b0;
      k_q          <= '0;
      f_q          <= '0;
      a_q          <= '0;
      w_q          <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      sample_q     <= '0;
      sync_out_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            // restart clears the accumulator before this tick's step
            base_phase_q <= (restart_i ? '0 : base_phase_q) + step_al;
            state_q      <= S_PHASE;
          end
        end
        S_PHASE: begin
          ph_q    <= ph_sum;
          sync_q  <= (ph_sum < step_al);
          state_q <= (wave_select_q == WAVE_SINE) ? S_POS : S_WAVE;
        end
        S_POS: begin
          k_q     <= pos[PW-1 -: AW];
          f_q     <= pos[31:16];
          state_q <= S_RDA;
        end
        S_RDA: begin
          state_q <= S_RDB;
        end
        S_RDB: begin
          a_q     <= rom_data;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          prod_q  <= mul_p;
          state_q <= S_WAVE;
        end
        S_WAVE: begin
          w_q     <= wave_d;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          prod_q  <= mul_p;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold here while the previous result is still waiting
          if (out_load) begin
            sample_q   <= sat;
            sync_out_q <= sync_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = sample_q;
  assign sync_pulse_o = sync_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_PHASE))
    else $error("input transfer did not start the sequencer");

  a_phase_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(base_phase_q))
    else $error("base phase moved without an input transfer");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == S_OUT) |=> (state_q == S_OUT))
    else $error("pending result would be overwritten");

endmodule
